// ===== rtl/core/assert_macros.svh =====
// Assertion helpers for the allocator RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define FFSA_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FFSA_ASSERT_NR(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define FFSA_ASSERT(lbl, clk, rst_n, prop, msg)
`define FFSA_ASSERT_NR(lbl, clk, prop, msg)
`endif
`endif

// ===== rtl/core/ffsa_pkg.sv =====
package ffsa_pkg;
    localparam int MAX_SEGMENTS_DEF   = 16;
    localparam int POOL_ADDR_BITS_DEF = 16;

    localparam int SIZE_W   = 17;
    localparam int ALIGN_W  = 4;
    localparam int OFF_W    = 16;
    localparam int STATUS_W = 2;

    localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NOFIT    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOTALLOC = 2'd2;
    localparam logic [STATUS_W-1:0] ST_FULL     = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    // Classified request handed from front to back
    typedef struct packed {
        logic              is_free;
        logic [SIZE_W-1:0] size;
        logic [OFF_W-1:0]  mask;
        logic [OFF_W-1:0]  off;
    } t_item;
endpackage

// ===== rtl/core/ffsa_ram.sv =====
module ffsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

// ===== rtl/core/ffsa_front.sv =====
module ffsa_front (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    output logic                          o_busy,
    input  logic                          i_cmd,
    input  logic [ffsa_pkg::SIZE_W-1:0]   i_req_size,
    input  logic [ffsa_pkg::ALIGN_W-1:0]  i_align_log2,
    input  logic [ffsa_pkg::OFF_W-1:0]    i_free_offset,
    output logic                          o_q_valid,
    output ffsa_pkg::t_item               o_q_item,
    input  logic                          i_q_pop
);
    ffsa_pkg::t_item r_q [2];
    logic            r_wp, r_rp;
    logic [1:0]      r_qn, n_qn;
    logic            accept;
    ffsa_pkg::t_item cls;

    assign o_busy    = (r_qn == 2'd2);
    assign accept    = i_start && !o_busy;
    assign o_q_valid = (r_qn != 2'd0);
    assign o_q_item  = r_q[r_rp];

    // classify: decode command and build the alignment mask
    always_comb begin
        cls.is_free = (i_cmd == ffsa_pkg::CMD_FREE);
        cls.size    = i_req_size;
        cls.mask    = ffsa_pkg::OFF_W'((17'd1 << i_align_log2) - 17'd1);
        cls.off     = i_free_offset;
    end

    always_comb begin
        n_qn = r_qn;
        if (accept && !i_q_pop) begin
            n_qn = r_qn + 2'd1;
        end else if (!accept && i_q_pop) begin
            n_qn = r_qn - 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp <= 1'b0;
            r_rp <= 1'b0;
            r_qn <= 2'd0;
        end else begin
            r_qn <= n_qn;
            if (accept) begin
                r_wp <= !r_wp;
            end
            if (i_q_pop) begin
                r_rp <= !r_rp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_q[r_wp] <= cls;
        end
    end
endmodule

// ===== rtl/core/ffsa_back.sv =====
module ffsa_back #(
    parameter int MAX_SEGMENTS   = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int POOL_ADDR_BITS = ffsa_pkg::POOL_ADDR_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [ffsa_pkg::SIZE_W-1:0]    i_cfg_data,
    input  logic                           i_q_valid,
    input  ffsa_pkg::t_item                i_q_item,
    output logic                           o_q_pop,
    output logic                           o_done,
    output logic [ffsa_pkg::STATUS_W-1:0]  o_status,
    output logic [ffsa_pkg::OFF_W-1:0]     o_alloc_offset
);
    localparam int PAB = POOL_ADDR_BITS;
    localparam int IW  = $clog2(MAX_SEGMENTS);
    localparam int CNW = $clog2(MAX_SEGMENTS + 1);
    localparam int DW  = 3 * PAB + 2;
    localparam int CW  = ((PAB > ffsa_pkg::SIZE_W) ? PAB : ffsa_pkg::SIZE_W) + 2;
    localparam int OW  = (PAB > ffsa_pkg::OFF_W) ? PAB : ffsa_pkg::OFF_W;
    localparam int PW  = ((PAB + 1) > ffsa_pkg::SIZE_W) ? (PAB + 1) : ffsa_pkg::SIZE_W;

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_SCAN = 3'd2;
    localparam logic [2:0] S_INS  = 3'd3;
    localparam logic [2:0] S_INSF = 3'd4;
    localparam logic [2:0] S_FNX  = 3'd5;
    localparam logic [2:0] S_ERS  = 3'd6;

    logic [2:0]                    r_state, n_state;
    logic [IW-1:0]                 r_i, n_i, r_k, n_k;
    logic [CNW-1:0]                r_cnt, n_cnt;
    logic [PAB:0]                  r_pool;
    ffsa_pkg::t_item               r_item, n_item;
    logic [PAB-1:0]                r_cur_aln, n_cur_aln, r_cur_st, n_cur_st;
    logic [PAB:0]                  r_cur_len, n_cur_len;
    logic [PAB-1:0]                r_new_st, n_new_st;
    logic [PAB:0]                  r_new_len, n_new_len;
    logic                          r_done, n_done;
    logic [ffsa_pkg::STATUS_W-1:0] r_status, n_status;
    logic [ffsa_pkg::OFF_W-1:0]    r_off, n_off;

    logic          we;
    logic [IW-1:0] waddr, raddr;
    logic [DW-1:0] wdata, rdata;

    logic           e_use;
    logic [PAB-1:0] e_aln, e_st;
    logic [PAB:0]   e_len;
    logic [CW-1:0]  s_x, m_x, a_x, end_x, sz_x, used_x, lim_x, len_x;
    logic           fit, hit;
    logic [CNW-1:0] i_ext, i1, i2, k_ext, k1, k2;
    logic [PW-1:0]  cfg_x, lim_p;

    ffsa_ram #(.WIDTH(DW), .DEPTH(MAX_SEGMENTS)) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign e_use = rdata[DW-1];
    assign e_aln = rdata[3*PAB:2*PAB+1];
    assign e_st  = rdata[2*PAB:PAB+1];
    assign e_len = rdata[PAB:0];

    assign s_x    = CW'(e_st);
    assign m_x    = CW'(r_item.mask);
    assign a_x    = (s_x + m_x) & ~m_x;
    assign len_x  = CW'(e_len);
    assign end_x  = s_x + len_x;
    assign sz_x   = CW'(r_item.size);
    assign used_x = a_x - s_x + sz_x;
    assign lim_x  = CW'(1) << PAB;
    assign fit    = !e_use && (a_x < lim_x) && ((a_x + sz_x) <= end_x);
    assign hit    = e_use && (OW'(e_aln) == OW'(r_item.off));

    assign i_ext = CNW'(r_i);
    assign i1    = i_ext + CNW'(1);
    assign i2    = i_ext + CNW'(2);
    assign k_ext = CNW'(r_k);
    assign k1    = k_ext + CNW'(1);
    assign k2    = k_ext + CNW'(2);

    assign cfg_x = PW'(i_cfg_data);
    assign lim_p = PW'(1) << PAB;

    always_comb begin
        n_state   = r_state;
        n_i       = r_i;
        n_k       = r_k;
        n_cnt     = r_cnt;
        n_item    = r_item;
        n_cur_aln = r_cur_aln;
        n_cur_st  = r_cur_st;
        n_cur_len = r_cur_len;
        n_new_st  = r_new_st;
        n_new_len = r_new_len;
        n_done    = 1'b0;
        n_status  = r_status;
        n_off     = r_off;
        we        = 1'b0;
        waddr     = r_i;
        wdata     = '0;
        raddr     = r_i;
        o_q_pop   = 1'b0;
        unique case (r_state)
            S_INIT: begin
                we      = 1'b1;
                waddr   = '0;
                wdata   = {1'b0, {PAB{1'b0}}, {PAB{1'b0}}, r_pool};
                n_cnt   = CNW'(1);
                n_state = S_IDLE;
            end
            S_IDLE: begin
                if (i_q_valid) begin
                    o_q_pop = 1'b1;
                    n_item  = i_q_item;
                    n_i     = '0;
                    raddr   = '0;
                    n_state = S_SCAN;
                end
            end
            S_SCAN: begin
                if (!r_item.is_free && fit) begin
                    if (len_x > used_x) begin
                        if (r_cnt >= CNW'(MAX_SEGMENTS)) begin
                            n_done   = 1'b1;
                            n_status = ffsa_pkg::ST_FULL;
                            n_off    = '0;
                            n_state  = S_IDLE;
                        end else begin
                            we        = 1'b1;
                            wdata     = {1'b1, a_x[PAB-1:0], e_st, used_x[PAB:0]};
                            n_new_st  = PAB'(s_x + used_x);
                            n_new_len = (PAB + 1)'(len_x - used_x);
                            n_off     = ffsa_pkg::OFF_W'(a_x);
                            if (r_cnt > i1) begin
                                raddr   = IW'(r_cnt - CNW'(1));
                                n_k     = IW'(r_cnt - CNW'(1));
                                n_state = S_INS;
                            end else begin
                                n_state = S_INSF;
                            end
                        end
                    end else begin
                        we       = 1'b1;
                        wdata    = {1'b1, a_x[PAB-1:0], e_st, e_len};
                        n_done   = 1'b1;
                        n_status = ffsa_pkg::ST_OK;
                        n_off    = ffsa_pkg::OFF_W'(a_x);
                        n_state  = S_IDLE;
                    end
                end else if (r_item.is_free && hit) begin
                    n_cur_aln = e_aln;
                    n_cur_st  = e_st;
                    n_cur_len = e_len;
                    if (i1 < r_cnt) begin
                        raddr   = IW'(i1);
                        n_state = S_FNX;
                    end else begin
                        we       = 1'b1;
                        wdata    = {1'b0, e_aln, e_st, e_len};
                        n_done   = 1'b1;
                        n_status = ffsa_pkg::ST_OK;
                        n_off    = '0;
                        n_state  = S_IDLE;
                    end
                end else if (i1 < r_cnt) begin
                    raddr = IW'(i1);
                    n_i   = IW'(i1);
                end else begin
                    n_done   = 1'b1;
                    n_status = r_item.is_free ? ffsa_pkg::ST_NOTALLOC : ffsa_pkg::ST_NOFIT;
                    n_off    = '0;
                    n_state  = S_IDLE;
                end
            end
            S_INS: begin
                we    = 1'b1;
                waddr = IW'(k1);
                wdata = rdata;
                if (k_ext > i1) begin
                    raddr = r_k - IW'(1);
                    n_k   = r_k - IW'(1);
                end else begin
                    n_state = S_INSF;
                end
            end
            S_INSF: begin
                we       = 1'b1;
                waddr    = IW'(i1);
                wdata    = {1'b0, {PAB{1'b0}}, r_new_st, r_new_len};
                n_cnt    = r_cnt + CNW'(1);
                n_done   = 1'b1;
                n_status = ffsa_pkg::ST_OK;
                n_state  = S_IDLE;
            end
            S_FNX: begin
                we       = 1'b1;
                n_status = ffsa_pkg::ST_OK;
                n_off    = '0;
                if (!e_use) begin
                    wdata = {1'b0, r_cur_aln, r_cur_st, r_cur_len + e_len};
                    if (i2 < r_cnt) begin
                        raddr   = IW'(i2);
                        n_k     = IW'(i1);
                        n_state = S_ERS;
                    end else begin
                        n_cnt   = r_cnt - CNW'(1);
                        n_done  = 1'b1;
                        n_state = S_IDLE;
                    end
                end else begin
                    wdata   = {1'b0, r_cur_aln, r_cur_st, r_cur_len};
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_ERS: begin
                we    = 1'b1;
                waddr = r_k;
                wdata = rdata;
                if (k2 < r_cnt) begin
                    raddr = IW'(k2);
                    n_k   = IW'(k1);
                end else begin
                    n_cnt   = r_cnt - CNW'(1);
                    n_done  = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_INIT;
            end
        endcase
        if (i_cfg_valid) begin
            n_state = S_INIT;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_cnt   <= CNW'(1);
            r_pool  <= (PAB + 1)'(lim_p);
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_done  <= n_done;
            if (i_cfg_valid) begin
                if (cfg_x == '0) begin
                    r_pool <= (PAB + 1)'(1);
                end else if (cfg_x > lim_p) begin
                    r_pool <= (PAB + 1)'(lim_p);
                end else begin
                    r_pool <= (PAB + 1)'(cfg_x);
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_i       <= n_i;
        r_k       <= n_k;
        r_item    <= n_item;
        r_cur_aln <= n_cur_aln;
        r_cur_st  <= n_cur_st;
        r_cur_len <= n_cur_len;
        r_new_st  <= n_new_st;
        r_new_len <= n_new_len;
        r_status  <= n_status;
        r_off     <= n_off;
    end

    assign o_done         = r_done;
    assign o_status       = r_status;
    assign o_alloc_offset = r_off;
endmodule

// ===== rtl/core/first_fit_segment_allocator.sv =====
// Each transaction: a table scan, plus a shift of the table on split/merge.
// Throughput: one transaction at a time in the back sequencer, set by the simple dual-port
//   table memory (one entry read and one written per cycle); a two-entry queue takes new ones.
// Result: strobed on o_done for exactly one cycle; the receiver cannot stall.
// Reset: synchronous, active low; pool 2^POOL_ADDR_BITS, one free segment written in
//   state S_INIT after reset or after a pool_size write.
`include "assert_macros.svh"

module first_fit_segment_allocator #(
    parameter int MAX_SEGMENTS   = ffsa_pkg::MAX_SEGMENTS_DEF,
    parameter int POOL_ADDR_BITS = ffsa_pkg::POOL_ADDR_BITS_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // request channel
    input  logic                           start,
    output logic                           busy,
    input  logic                           i_cmd,
    input  logic [ffsa_pkg::SIZE_W-1:0]    i_req_size,
    input  logic [ffsa_pkg::ALIGN_W-1:0]   i_align_log2,
    input  logic [ffsa_pkg::OFF_W-1:0]     i_free_offset,
    // configuration channel: pool_size
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [ffsa_pkg::SIZE_W-1:0]    i_cfg_data,
    // result strobe
    output logic                           o_done,
    output logic [ffsa_pkg::STATUS_W-1:0]  o_status,
    output logic [ffsa_pkg::OFF_W-1:0]     o_alloc_offset
);
    logic            q_valid;
    logic            q_pop;
    ffsa_pkg::t_item q_item;

    // Always take configuration; it must be written only while the block is idle (unchecked)
    assign o_cfg_ready = 1'b1;

    // Front: accept and classify requests, hold them in a short queue
    ffsa_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_start       (start),
        .o_busy        (busy),
        .i_cmd         (i_cmd),
        .i_req_size    (i_req_size),
        .i_align_log2  (i_align_log2),
        .i_free_offset (i_free_offset),
        .o_q_valid     (q_valid),
        .o_q_item      (q_item),
        .i_q_pop       (q_pop)
    );

    // Back: scan the segment table, split on allocate, merge forward on free
    ffsa_back #(
        .MAX_SEGMENTS   (MAX_SEGMENTS),
        .POOL_ADDR_BITS (POOL_ADDR_BITS)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_valid    (i_cfg_valid && o_cfg_ready),
        .i_cfg_data     (i_cfg_data),
        .i_q_valid      (q_valid),
        .i_q_item       (q_item),
        .o_q_pop        (q_pop),
        .o_done         (o_done),
        .o_status       (o_status),
        .o_alloc_offset (o_alloc_offset)
    );

    // Failed transactions never carry an offset
    `FFSA_ASSERT(a_fail_zero_off, i_clk, i_rst_n, (o_done && (o_status != ffsa_pkg::ST_OK)) |-> (o_alloc_offset == '0), "offset on failed result")
    // Result strobes are never back to back
    `FFSA_ASSERT(a_done_gap, i_clk, i_rst_n, o_done |=> !o_done, "back-to-back result strobes")
    // A pop only happens when the queue holds a transaction
    `FFSA_ASSERT(a_pop_valid, i_clk, i_rst_n, q_pop |-> q_valid, "pop from empty queue")
    // No result straight out of reset
    `FFSA_ASSERT_NR(a_rst_quiet, i_clk, !i_rst_n |=> !o_done, "result strobe after reset")
endmodule
